@@ src/qpd_pkg.sv @@
// Shared types and constants for the QRS peak detector.
`default_nettype none

package qpd_pkg;

    // Width of the bandpass peak height register.
    localparam int BP_THR_W = 15;

    // Reset value of the bandpass peak height register.
    localparam logic [BP_THR_W-1:0] BP_THR_RESET = 15'd1850;

    // Depth of the bandpass window and its peak test taps.
    localparam int BP_DEPTH   = 5;
    localparam int BP_TAP_OLD = 4;
    localparam int BP_TAP_MID = 2;

    // Decision for one sample: whether a beat goes out, and its mark.
    typedef struct packed {
        logic emit;
        logic mark;
    } t_det_result;

endpackage

`default_nettype wire

@@ src/qrs_peak_detector.sv @@
// Top level of the QRS peak detector: handshakes, height register and result register.
//
//   Channel   Direction  Content
//   s_axis    in         tdata: bandpass, average, derivative (low bits first)
//   m_axis    out        tdata: bandpass, average, derivative echo; tuser: peak mark
//   cfg       in         bandpass peak height, 15 bits, write only
//
// One sample per cycle sustained while the output does not stall. A sample
// passes from input beat to result beat through the sample windows, then the
// peak tests into the result register. Synchronous active-low reset clears
// windows, thresholds, mode and the height register (to 1850). A stalled output
// holds the result register and any windowed sample, which back-pressures the input.
`default_nettype none

module qrs_peak_detector #(
    parameter int WINDOW_LEN   = 21,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // bandpass [SW-1:0], average [2SW-1:SW], derivative [3SW-1:2SW], zero pad
    input  wire  [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // bandpass [SW-1:0], average [2SW-1:SW], derivative [3SW-1:2SW], zero pad
    output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // peak mark [0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    input  wire                              i_cfg_wr_en,
    input  wire  [qpd_pkg::BP_THR_W-1:0]     i_cfg_wr_data
);

    localparam int DW = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SW = SAMPLE_WIDTH;

    logic [qpd_pkg::BP_THR_W-1:0] r_bp_thr;
    logic                         r_stage_valid;
    logic                         r_out_valid;
    logic [DW-1:0]                r_out_data;
    logic                         r_out_mark;

    logic                  in_beat;
    logic                  advance;
    logic                  consume;
    qpd_pkg::t_det_result  det;

    logic signed [SW-1:0] bp_old, bp_mid, bp_new;
    logic signed [SW-1:0] av_old, av_mid, av_new;
    logic signed [SW-1:0] dv_old, dv_mid, dv_new;

    // Handshake: the windowed sample moves on when the result register frees up.
    assign advance       = !r_out_valid || m_axis_tready;
    assign consume       = r_stage_valid && advance;
    assign s_axis_tready = !r_stage_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Bandpass peak height register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_thr <= qpd_pkg::BP_THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_bp_thr <= i_cfg_wr_data;
        end
    end

    qpd_window #(
        .WINDOW_LEN   (WINDOW_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_shift      (in_beat),
        .i_bandpass   (s_axis_tdata[SW-1:0]),
        .i_average    (s_axis_tdata[2*SW-1:SW]),
        .i_derivative (s_axis_tdata[3*SW-1:2*SW]),
        .o_bp_old     (bp_old),
        .o_bp_mid     (bp_mid),
        .o_bp_new     (bp_new),
        .o_av_old     (av_old),
        .o_av_mid     (av_mid),
        .o_av_new     (av_new),
        .o_dv_old     (dv_old),
        .o_dv_mid     (dv_mid),
        .o_dv_new     (dv_new)
    );

    qpd_detect #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_detect (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (consume),
        .i_bp_threshold (r_bp_thr),
        .i_bp_old       (bp_old),
        .i_bp_mid       (bp_mid),
        .i_bp_new       (bp_new),
        .i_av_old       (av_old),
        .i_av_mid       (av_mid),
        .i_av_new       (av_new),
        .i_dv_old       (dv_old),
        .i_dv_mid       (dv_mid),
        .i_dv_new       (dv_new),
        .o_result       (det)
    );

    // Marks that the windows hold a sample not yet decided.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (in_beat) begin
            r_stage_valid <= 1'b1;
        end else if (consume) begin
            r_stage_valid <= 1'b0;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume) begin
            r_out_valid <= det.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: echo of the newest taps and the peak mark.
    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_out_data <= DW'({dv_new, av_new, bp_new});
            r_out_mark <= det.mark;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_mark;

endmodule

`default_nettype wire

@@ src/qpd_window.sv @@
// Sample windows for the bandpass, moving-average and derivative channels.
`default_nettype none

module qpd_window #(
    parameter int WINDOW_LEN   = 21,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_shift,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_bandpass,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_average,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_derivative,
    output logic signed [SAMPLE_WIDTH-1:0] o_bp_old,
    output logic signed [SAMPLE_WIDTH-1:0] o_bp_mid,
    output logic signed [SAMPLE_WIDTH-1:0] o_bp_new,
    output logic signed [SAMPLE_WIDTH-1:0] o_av_old,
    output logic signed [SAMPLE_WIDTH-1:0] o_av_mid,
    output logic signed [SAMPLE_WIDTH-1:0] o_av_new,
    output logic signed [SAMPLE_WIDTH-1:0] o_dv_old,
    output logic signed [SAMPLE_WIDTH-1:0] o_dv_mid,
    output logic signed [SAMPLE_WIDTH-1:0] o_dv_new
);

    localparam int TAP_OLD = WINDOW_LEN - 1;
    localparam int TAP_MID = (WINDOW_LEN - 1) / 2;

    logic signed [SAMPLE_WIDTH-1:0] r_bp [qpd_pkg::BP_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_av [WINDOW_LEN];
    logic signed [SAMPLE_WIDTH-1:0] r_dv [WINDOW_LEN];

    // Shift lines, tap 0 holds the newest sample; reset clears every tap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qpd_pkg::BP_DEPTH; i++) begin
                r_bp[i] <= '0;
            end
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_av[i] <= '0;
                r_dv[i] <= '0;
            end
        end else if (i_shift) begin
            r_bp[0] <= i_bandpass;
            r_av[0] <= i_average;
            r_dv[0] <= i_derivative;
            for (int i = 1; i < qpd_pkg::BP_DEPTH; i++) begin
                r_bp[i] <= r_bp[i-1];
            end
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_av[i] <= r_av[i-1];
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    // Fixed taps used by the peak tests.
    assign o_bp_old = r_bp[qpd_pkg::BP_TAP_OLD];
    assign o_bp_mid = r_bp[qpd_pkg::BP_TAP_MID];
    assign o_bp_new = r_bp[0];
    assign o_av_old = r_av[TAP_OLD];
    assign o_av_mid = r_av[TAP_MID];
    assign o_av_new = r_av[0];
    assign o_dv_old = r_dv[TAP_OLD];
    assign o_dv_mid = r_dv[TAP_MID];
    assign o_dv_new = r_dv[0];

endmodule

`default_nettype wire

@@ src/qpd_detect.sv @@
// Peak tests, adaptive thresholds and the idle/search mode for the QRS peak detector.
`default_nettype none

module qpd_detect #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_step,
    input  wire  [qpd_pkg::BP_THR_W-1:0]          i_bp_threshold,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_bp_old,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_bp_mid,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_bp_new,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_av_old,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_av_mid,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_av_new,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_dv_old,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_dv_mid,
    input  wire  signed [SAMPLE_WIDTH-1:0]        i_dv_new,
    output qpd_pkg::t_det_result                  o_result
);

    // Compare width covers samples, the 15-bit height and the sign.
    localparam int CW = ((SAMPLE_WIDTH > qpd_pkg::BP_THR_W) ?
                         SAMPLE_WIDTH : qpd_pkg::BP_THR_W) + 2;
    // Width of three times a positive sample.
    localparam int XW = SAMPLE_WIDTH + 1;

    logic [SAMPLE_WIDTH-1:0] r_dv_thr;
    logic [XW-1:0]           r_av_thr;
    logic                    r_searching;
    logic                    r_latch;

    logic [SAMPLE_WIDTH-1:0] n_dv_thr;
    logic [XW-1:0]           n_av_thr;
    logic                    n_searching;
    logic                    n_latch;

    logic          dv_peak;
    logic          av_peak_cur;
    logic          av_peak_new;
    logic          bp_peak;
    logic [XW-1:0] triple_d;
    logic [XW-1:0] tenth;

    // Sign extension of a sample to the compare width.
    function automatic logic signed [CW-1:0] sx(input logic [SAMPLE_WIDTH-1:0] v);
        sx = $signed({{(CW-SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v});
    endfunction

    // All three taps positive, a strict maximum in the middle, at or above t.
    function automatic logic is_peak(input logic signed [CW-1:0] o,
                                     input logic signed [CW-1:0] m,
                                     input logic signed [CW-1:0] n,
                                     input logic signed [CW-1:0] t);
        is_peak = (o > 0) && (m > 0) && (n > 0) && (o < m) && (m > n) && (m >= t);
    endfunction

    // Floor of x / 10 by shifts and adds, then one correction step.
    function automatic logic [XW-1:0] div10(input logic [XW-1:0] x);
        logic [XW-1:0] q;
        logic [XW-1:0] r;
        q = (x >> 1) + (x >> 2);
        for (int s = 4; s < XW; s = s * 2) begin
            q = q + (q >> s);
        end
        q = q >> 3;
        r = x - (q << 3) - (q << 1);
        if (r > XW'(9)) begin
            q = q + XW'(1);
        end
        div10 = q;
    endfunction

    // Threshold candidates from the derivative middle tap.
    assign triple_d = {1'b0, i_dv_mid} + {i_dv_mid, 1'b0};
    assign tenth    = div10(triple_d);

    // Peak tests over the window taps.
    assign dv_peak = is_peak(sx(i_dv_old), sx(i_dv_mid), sx(i_dv_new),
                             $signed(CW'(r_dv_thr)));
    assign av_peak_cur = is_peak(sx(i_av_old), sx(i_av_mid), sx(i_av_new),
                                 $signed(CW'(r_av_thr)));
    assign av_peak_new = is_peak(sx(i_av_old), sx(i_av_mid), sx(i_av_new),
                                 $signed(CW'({1'b0, triple_d[XW-1:1]})));
    assign bp_peak = is_peak(sx(i_bp_old), sx(i_bp_mid), sx(i_bp_new),
                             $signed(CW'(i_bp_threshold)));

    // Mode decision and next state for the sample in the window.
    always_comb begin
        n_dv_thr     = r_dv_thr;
        n_av_thr     = r_av_thr;
        n_searching  = r_searching;
        n_latch      = r_latch;
        o_result     = '{emit: 1'b1, mark: 1'b0};
        if (!r_searching) begin
            if (dv_peak) begin
                n_dv_thr    = tenth[SAMPLE_WIDTH-1:0];
                n_av_thr    = {1'b0, triple_d[XW-1:1]};
                n_searching = !av_peak_new;
                o_result.emit = 1'b0;
            end
        end else begin
            if (bp_peak) begin
                o_result.mark = !r_latch;
                n_latch       = !r_latch;
            end
            if (av_peak_cur) begin
                n_searching = 1'b0;
            end
        end
    end

    // State registers advance once per sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_thr    <= '0;
            r_av_thr    <= '0;
            r_searching <= 1'b0;
            r_latch     <= 1'b0;
        end else if (i_step) begin
            r_dv_thr    <= n_dv_thr;
            r_av_thr    <= n_av_thr;
            r_searching <= n_searching;
            r_latch     <= n_latch;
        end
    end

endmodule

`default_nettype wire
